/* hw/rtl/bclm_pkg.sv */
// Shared types, constants and helper functions of the battery charge level monitor.
// No dependencies; every other file of the block refers to this package by scoped names.
package bclm_pkg;

    // Field widths
    localparam int unsigned CMD_W     = 2;
    localparam int unsigned ADC_W     = 12;
    localparam int unsigned RATIO_W   = 16;
    localparam int unsigned MV_W      = 16;
    localparam int unsigned PCT_W     = 7;
    localparam int unsigned MS_W      = 32;
    localparam int unsigned CFG_IDX_W = 1;
    localparam int unsigned CFG_DAT_W = 32;

    // Divider ratio is unsigned Q4.12
    localparam int unsigned RATIO_FRAC = 12;
    localparam int unsigned PROD_W     = ADC_W + RATIO_W + 1;

    // Command codes
    typedef enum logic [CMD_W-1:0] {
        CMD_TICK   = 2'd0,
        CMD_UPDATE = 2'd1,
        CMD_FORCE  = 2'd2,
        CMD_CLEAR  = 2'd3
    } t_cmd;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_INTERVAL = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_RATIO    = 1'b1;

    // Register reset values
    localparam logic [MS_W-1:0]    INTERVAL_RST = 32'd1000;
    localparam logic [RATIO_W-1:0] RATIO_RST    = 16'd8192;

    // LiPo curve break points (mV, percent)
    localparam logic [MV_W-1:0]  CURVE_MV_FULL = 16'd4200;
    localparam logic [MV_W-1:0]  CURVE_MV_HIGH = 16'd4000;
    localparam logic [MV_W-1:0]  CURVE_MV_MID  = 16'd3800;
    localparam logic [MV_W-1:0]  CURVE_MV_LOW  = 16'd3650;
    localparam logic [MV_W-1:0]  CURVE_MV_EMPTY = 16'd3300;
    localparam logic [PCT_W-1:0] CURVE_PCT_FULL = 7'd100;
    localparam logic [PCT_W-1:0] CURVE_PCT_HIGH = 7'd80;
    localparam logic [PCT_W-1:0] CURVE_PCT_MID  = 7'd50;
    localparam logic [PCT_W-1:0] CURVE_PCT_LOW  = 7'd20;
    localparam logic [PCT_W-1:0] CURVE_PCT_EMPTY = 7'd0;

    // floor(n / 10) for n below 1024: n * 205 >> 11
    function automatic logic [PCT_W-1:0] div10(input logic [9:0] n);
        logic [17:0] prod;
        prod  = 18'(n) * 18'd205;
        return prod[17:11];
    endfunction

    // floor(n / 70) for n below 2048: n * 1873 >> 17
    function automatic logic [PCT_W-1:0] div70(input logic [10:0] n);
        logic [21:0] prod;
        prod  = 22'(n) * 22'd1873;
        return {2'b00, prod[21:17]};
    endfunction

endpackage

/* hw/rtl/bclm_if.sv */
// Handshake channel interfaces of the battery charge level monitor: items in, results out,
// configuration writes. Depends on bclm_pkg for widths.
interface bclm_in_if;
    logic                          valid;
    logic                          ready;
    logic [bclm_pkg::CMD_W-1:0]    cmd;
    logic [bclm_pkg::ADC_W-1:0]    adc_millivolts;

    modport source (output valid, cmd, adc_millivolts, input ready);
    modport sink   (input valid, cmd, adc_millivolts, output ready);
endinterface

interface bclm_out_if;
    logic                          valid;
    logic                          ready;
    logic [bclm_pkg::PCT_W-1:0]    charge_percent;
    logic [bclm_pkg::MV_W-1:0]     battery_millivolts;
    logic [bclm_pkg::ADC_W-1:0]    held_adc_millivolts;
    logic                          display_dirty;
    logic                          update_taken;

    modport source (output valid, charge_percent, battery_millivolts, held_adc_millivolts,
                     display_dirty, update_taken, input ready);
    modport sink   (input valid, charge_percent, battery_millivolts, held_adc_millivolts,
                     display_dirty, update_taken, output ready);
endinterface

interface bclm_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [bclm_pkg::CFG_IDX_W-1:0]   index;
    logic [bclm_pkg::CFG_DAT_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* hw/rtl/battery_charge_level_monitor.sv */
// Top level of the battery charge level monitor: item register, state update, result register.
// Depends on bclm_pkg, the channel interfaces, bclm_scale and bclm_curve.

// The block takes one command item per clock cycle while the result side is not stalled and
// returns exactly one result item for each, in order, through the item register and then the
// result register. Unstalled, the throughput is one item per cycle: the two registers form a
// two-entry pipeline. The divider-scaling multiplier, the curve lookup, the due-time compare
// and the dirty test all lie in the stage between the two registers that updates the state,
// so each item sees the state left by the one before it. Each result shows the stored
// percentage, battery voltage, held ADC reading and dirty flag as they stand after its
// command, plus whether that command took a reading. Configuration writes are always
// accepted; write them only while no item is in flight, since an item waiting in the item
// register reads the registers when it advances.
module battery_charge_level_monitor (
    input  logic          i_clk,
    input  logic          i_rst_n,
    bclm_in_if.sink       i_item,
    bclm_out_if.source    o_result,
    bclm_cfg_if.sink      i_cfg
);
    // Configuration registers
    logic [bclm_pkg::MS_W-1:0]    r_interval_ms;
    logic [bclm_pkg::RATIO_W-1:0] r_ratio_q12;

    // Item register
    logic                         r_in_valid;
    bclm_pkg::t_cmd               r_in_cmd;
    logic [bclm_pkg::ADC_W-1:0]   r_in_adc;

    // Block state; all but the time counters are shown directly on the result channel
    logic [bclm_pkg::MS_W-1:0]    r_now_ms,   n_now_ms;
    logic [bclm_pkg::MS_W-1:0]    r_last_ms,  n_last_ms;
    logic [bclm_pkg::MV_W-1:0]    r_batt_mv,  n_batt_mv;
    logic [bclm_pkg::ADC_W-1:0]   r_adc_mv,   n_adc_mv;
    logic [bclm_pkg::PCT_W-1:0]   r_pct,      n_pct;
    logic                         r_dirty,    n_dirty;
    logic                         r_taken,    n_taken;
    logic                         r_out_valid;

    logic [bclm_pkg::MV_W-1:0]    w_scaled_mv;
    logic [bclm_pkg::PCT_W-1:0]   w_pct;
    logic [bclm_pkg::MV_W-1:0]    w_diff;
    logic                         w_take;
    logic                         w_adv;
    logic                         w_fire;
    logic                         w_in_acc;

    // Scale held reading; user must keep ratio stable while items in flight, not enforced
    bclm_scale u_scale (
        .i_adc       (r_in_adc),
        .i_ratio_q12 (r_ratio_q12),
        .o_mv        (w_scaled_mv)
    );

    bclm_curve u_curve (
        .i_mv      (w_scaled_mv),
        .o_percent (w_pct)
    );

    // Advance the pipeline when the result register is empty or being drained
    assign w_adv        = !r_out_valid || o_result.ready;
    assign w_fire       = r_in_valid && w_adv;
    assign i_item.ready = !r_in_valid || w_adv;
    assign w_in_acc     = i_item.valid && i_item.ready;
    assign i_cfg.ready  = 1'b1;

    assign w_diff = (w_scaled_mv > r_batt_mv) ? (w_scaled_mv - r_batt_mv)
                                              : (r_batt_mv - w_scaled_mv);

    // Next state for the command in the item register
    always_comb begin
        n_now_ms  = r_now_ms;
        n_last_ms = r_last_ms;
        n_batt_mv = r_batt_mv;
        n_adc_mv  = r_adc_mv;
        n_pct     = r_pct;
        n_dirty   = r_dirty;
        w_take    = 1'b0;
        case (r_in_cmd)
            bclm_pkg::CMD_TICK: begin
                n_now_ms = r_now_ms + bclm_pkg::MS_W'(1);
            end
            bclm_pkg::CMD_UPDATE: begin
                // wrapped elapsed time against the interval
                w_take = (r_now_ms - r_last_ms) >= r_interval_ms;
            end
            bclm_pkg::CMD_FORCE: begin
                w_take = 1'b1;
            end
            bclm_pkg::CMD_CLEAR: begin
                n_dirty = 1'b0;
            end
            default: begin
                n_dirty = r_dirty;
            end
        endcase
        if (w_take) begin
            n_batt_mv = w_scaled_mv;
            n_adc_mv  = r_in_adc;
            n_pct     = w_pct;
            n_last_ms = r_now_ms;
            // mark for redraw on a new percentage or a move of more than 1 mV
            if ((w_pct != r_pct) || (w_diff > bclm_pkg::MV_W'(1))) begin
                n_dirty = 1'b1;
            end
        end
        n_taken = w_take;
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_interval_ms <= bclm_pkg::INTERVAL_RST;
            r_ratio_q12   <= bclm_pkg::RATIO_RST;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (i_cfg.index)
                bclm_pkg::REG_INTERVAL: r_interval_ms <= i_cfg.data;
                bclm_pkg::REG_RATIO:    r_ratio_q12   <= i_cfg.data[bclm_pkg::RATIO_W-1:0];
                default: begin
                    r_interval_ms <= r_interval_ms;
                end
            endcase
        end
    end

    // Item register: load on accept, drop once passed on
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_acc) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_in_cmd <= bclm_pkg::t_cmd'(i_item.cmd);
            r_in_adc <= i_item.adc_millivolts;
        end
    end

    // State and result register: advance together, hold while the result is stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_now_ms    <= '0;
            r_last_ms   <= '0;
            r_batt_mv   <= '0;
            r_adc_mv    <= '0;
            r_pct       <= '0;
            r_dirty     <= 1'b1;
            r_taken     <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_now_ms    <= n_now_ms;
            r_last_ms   <= n_last_ms;
            r_batt_mv   <= n_batt_mv;
            r_adc_mv    <= n_adc_mv;
            r_pct       <= n_pct;
            r_dirty     <= n_dirty;
            r_taken     <= n_taken;
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_result.valid               = r_out_valid;
    assign o_result.charge_percent      = r_pct;
    assign o_result.battery_millivolts  = r_batt_mv;
    assign o_result.held_adc_millivolts = r_adc_mv;
    assign o_result.display_dirty       = r_dirty;
    assign o_result.update_taken        = r_taken;

endmodule

/* hw/rtl/bclm_scale.sv */
// Divider scaling: ADC millivolts times the Q4.12 ratio, rounded half up, saturated.
// Depends on bclm_pkg.
module bclm_scale (
    input  logic [bclm_pkg::ADC_W-1:0]   i_adc,
    input  logic [bclm_pkg::RATIO_W-1:0] i_ratio_q12,
    output logic [bclm_pkg::MV_W-1:0]    o_mv
);
    localparam int unsigned SHIFT_W = bclm_pkg::PROD_W - bclm_pkg::RATIO_FRAC;

    logic [bclm_pkg::PROD_W-1:0] w_prod;
    logic [SHIFT_W-1:0]          w_shifted;

    assign w_prod    = bclm_pkg::PROD_W'(i_adc) * bclm_pkg::PROD_W'(i_ratio_q12)
                     + bclm_pkg::PROD_W'(1 << (bclm_pkg::RATIO_FRAC - 1));
    assign w_shifted = w_prod[bclm_pkg::PROD_W-1:bclm_pkg::RATIO_FRAC];

    // clamp to full scale when the top bit is set
    assign o_mv = (w_shifted[SHIFT_W-1:bclm_pkg::MV_W] != '0) ? '1
                                                              : w_shifted[bclm_pkg::MV_W-1:0];
endmodule

/* hw/rtl/bclm_curve.sv */
// Piecewise linear LiPo curve: battery millivolts to state of charge, round half up.
// Depends on bclm_pkg for the curve points and the constant dividers.
module bclm_curve (
    input  logic [bclm_pkg::MV_W-1:0]  i_mv,
    output logic [bclm_pkg::PCT_W-1:0] o_percent
);
    logic [bclm_pkg::MV_W-1:0] w_x_high;
    logic [bclm_pkg::MV_W-1:0] w_x_mid;
    logic [bclm_pkg::MV_W-1:0] w_x_low;
    logic [bclm_pkg::MV_W-1:0] w_x_empty;
    logic [9:0]                w_n_high;
    logic [9:0]                w_n_mid;
    logic [9:0]                w_n_low;
    logic [10:0]               w_n_empty;

    assign w_x_high  = i_mv - bclm_pkg::CURVE_MV_HIGH;
    assign w_x_mid   = i_mv - bclm_pkg::CURVE_MV_MID;
    assign w_x_low   = i_mv - bclm_pkg::CURVE_MV_LOW;
    assign w_x_empty = i_mv - bclm_pkg::CURVE_MV_EMPTY;

    // Each segment reduces to floor(n / d) with small constant d:
    // top (x+5)/10, upper middle (3x+10)/20, lower middle (2x+5)/10, bottom (4x+35)/70
    assign w_n_high  = w_x_high[9:0] + 10'd5;
    assign w_n_mid   = 10'(({2'b00, w_x_mid[7:0]} * 10'd3 + 10'd10) >> 1);
    assign w_n_low   = {w_x_low[8:0], 1'b0} + 10'd5;
    assign w_n_empty = {w_x_empty[8:0], 2'b00} + 11'd35;

    always_comb begin
        if (i_mv >= bclm_pkg::CURVE_MV_FULL) begin
            o_percent = bclm_pkg::CURVE_PCT_FULL;
        end else if (i_mv <= bclm_pkg::CURVE_MV_EMPTY) begin
            o_percent = bclm_pkg::CURVE_PCT_EMPTY;
        end else if (i_mv >= bclm_pkg::CURVE_MV_HIGH) begin
            o_percent = bclm_pkg::CURVE_PCT_HIGH + bclm_pkg::div10(w_n_high);
        end else if (i_mv >= bclm_pkg::CURVE_MV_MID) begin
            o_percent = bclm_pkg::CURVE_PCT_MID + bclm_pkg::div10(w_n_mid);
        end else if (i_mv >= bclm_pkg::CURVE_MV_LOW) begin
            o_percent = bclm_pkg::CURVE_PCT_LOW + bclm_pkg::div10(w_n_low);
        end else begin
            o_percent = bclm_pkg::CURVE_PCT_EMPTY + bclm_pkg::div70(w_n_empty);
        end
    end
endmodule

/* hw/rtl/bclm_checker.sv */
// Port-level assertions for the battery charge level monitor, bound to the top level.
// Depends on bclm_pkg and on the top level battery_charge_level_monitor.
module bclm_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_out_valid,
    input logic                         i_out_ready,
    input logic [bclm_pkg::PCT_W-1:0]   i_pct,
    input logic [bclm_pkg::MV_W-1:0]    i_mv,
    input logic [bclm_pkg::ADC_W-1:0]   i_adc,
    input logic                         i_dirty,
    input logic                         i_taken
);
    // no result is offered in the cycle after reset
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_pct) && $stable(i_mv)
            && $stable(i_adc) && $stable(i_dirty) && $stable(i_taken))
        else $error("stalled result changed");

    // curve clamps agree with the shown voltage
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_mv >= bclm_pkg::CURVE_MV_FULL) |-> i_pct == bclm_pkg::CURVE_PCT_FULL)
        else $error("voltage at or above full but percent not full");

    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_mv <= bclm_pkg::CURVE_MV_EMPTY) |-> i_pct == bclm_pkg::CURVE_PCT_EMPTY)
        else $error("voltage at or below empty but percent not zero");
endmodule

bind battery_charge_level_monitor bclm_checker u_bclm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready),
    .i_pct       (o_result.charge_percent),
    .i_mv        (o_result.battery_millivolts),
    .i_adc       (o_result.held_adc_millivolts),
    .i_dirty     (o_result.display_dirty),
    .i_taken     (o_result.update_taken)
);
